FILE: src/mst_pkg.sv
package mst_pkg;

  localparam int unsigned DEF_SLOT_COUNT  = 16;
  localparam int unsigned DEF_QUEUE_DEPTH = 4;

  // Slot field width inside a queued command; covers the largest supported slot count.
  localparam int unsigned SLOT_IDX_MAX_W = 6;

  localparam logic [31:0] LIFT_VALUE = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    REQ_SLOT        = 3'd0,
    REQ_TRACK_ID    = 3'd1,
    REQ_POS_X       = 3'd2,
    REQ_POS_Y       = 3'd3,
    REQ_TOUCH_MAJOR = 3'd4,
    REQ_WIDTH_MAJOR = 3'd5,
    REQ_IGNORED     = 3'd6
  } req_kind_e;

  typedef enum logic [2:0] {
    CMD_CLEAR       = 3'd0,
    CMD_WRITE_X     = 3'd1,
    CMD_WRITE_Y     = 3'd2,
    CMD_WRITE_TOUCH = 3'd3,
    CMD_REPORT      = 3'd4
  } cmd_op_e;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] event_value;
  } req_t;

  typedef struct packed {
    logic [3:0]  slot_number;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] size_ratio;
    logic        divide_fault;
  } res_t;

  typedef struct packed {
    cmd_op_e                   op;
    logic [SLOT_IDX_MAX_W-1:0] slot;
    logic [31:0]               value;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

FILE: src/multitouch_slot_tracker_top.sv
// Multi-touch slot tracker for protocol B event streams.
//
// Input: one event per transaction on req_i, taken at a rising edge where start is
// high and busy is low. The front end updates the slot selection, the open slots
// and the pending-report flag at once and queues any store write or report.
// busy is high only while the command queue (QUEUE_DEPTH entries) is full.
//
// Output: a report appears on result_o for exactly one cycle with result_valid_o
// high. There is no back pressure; the receiver must take it in that cycle.
//
// Back end: store writes and slot clears retire as they are popped in the idle state.
// A report holds the back end for its pop, the registered store read and 32 steps of
// the restoring divider, and the result then passes the output register. A zero
// width major skips the divider and reports straight from the store read.
// Events that queue nothing are taken one per cycle whenever busy is low.
//
// Reset: asynchronous and active low. It closes all slots, selects slot 0, clears
// the pending flag and empties the queue. The position and size stores are not
// cleared; a slot's entries are zeroed when it opens.
module multitouch_slot_tracker_top import mst_pkg::*; #(
  parameter int unsigned SLOT_COUNT  = DEF_SLOT_COUNT,
  parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic result_valid_o,
  output res_t result_o
);

  logic          accept;
  logic          push;
  logic          pop;
  cmd_t          cmd;
  cmd_t          head;
  queue_status_t qstat;

  assign busy   = qstat.full;
  assign accept = start && !qstat.full;

  mst_front #(.SLOT_COUNT(SLOT_COUNT)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .req_i   (req_i),
    .push_o  (push),
    .cmd_o   (cmd)
  );

  mst_cmd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd),
    .pop_i   (pop),
    .head_o  (head),
    .status_o(qstat)
  );

  mst_back #(.SLOT_COUNT(SLOT_COUNT)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .qstat_i       (qstat),
    .pop_o         (pop),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

endmodule

FILE: src/mst_ram.sv
module mst_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/mst_cmd_queue.sv
module mst_cmd_queue import mst_pkg::*; #(
  parameter int unsigned DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  cmd_t          data_i,
  input  logic          pop_i,
  output cmd_t          head_o,
  output queue_status_t status_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cmd_t             entry_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d;
  logic [PTR_W-1:0] rptr_q, rptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= data_i;
    end
  end

  assign head_o         = entry_q[rptr_q];
  assign status_o.full  = (cnt_q == CNT_W'(DEPTH));
  assign status_o.empty = (cnt_q == '0);

endmodule

FILE: src/mst_front.sv
module mst_front import mst_pkg::*; #(
  parameter int unsigned SLOT_COUNT = DEF_SLOT_COUNT
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic accept_i,
  input  req_t req_i,
  output logic push_o,
  output cmd_t cmd_o
);

  localparam int unsigned SLOT_W = $clog2(SLOT_COUNT);
  localparam int unsigned CNT_W  = $clog2(SLOT_COUNT + 1);

  logic [SLOT_W-1:0]     cur_slot_q, cur_slot_d;
  logic [SLOT_COUNT-1:0] open_q, open_d;
  logic [CNT_W-1:0]      open_cnt_q, open_cnt_d;
  logic                  pending_q, pending_d;
  logic                  live;

  always_comb begin
    cur_slot_d = cur_slot_q;
    open_d     = open_q;
    open_cnt_d = open_cnt_q;
    pending_d  = pending_q;
    push_o     = 1'b0;
    cmd_o.op    = CMD_CLEAR;
    cmd_o.slot  = SLOT_IDX_MAX_W'(cur_slot_q);
    cmd_o.value = req_i.event_value;
    live       = open_q[cur_slot_q];

    if (accept_i) begin
      case (req_kind_e'(req_i.req_type))
        REQ_SLOT: begin
          if (req_i.event_value < 32'(SLOT_COUNT)) begin
            cur_slot_d = req_i.event_value[SLOT_W-1:0];
          end
        end
        REQ_TRACK_ID: begin
          if (req_i.event_value != LIFT_VALUE) begin
            // A new contact starts from zeroed fields; the back end clears the stores.
            if (!live) begin
              open_d[cur_slot_q] = 1'b1;
              open_cnt_d         = open_cnt_q + 1'b1;
              push_o             = 1'b1;
              cmd_o.op           = CMD_CLEAR;
            end
          end else begin
            if (live) begin
              open_d[cur_slot_q] = 1'b0;
              open_cnt_d         = open_cnt_q - 1'b1;
            end
            if (open_cnt_d <= CNT_W'(1)) begin
              cur_slot_d = '0;
            end
          end
        end
        REQ_POS_X: begin
          if (live) begin
            push_o    = 1'b1;
            cmd_o.op  = CMD_WRITE_X;
            pending_d = 1'b1;
          end
        end
        REQ_POS_Y: begin
          if (live) begin
            push_o   = 1'b1;
            cmd_o.op = CMD_WRITE_Y;
          end
        end
        REQ_TOUCH_MAJOR: begin
          if (live) begin
            push_o   = 1'b1;
            cmd_o.op = CMD_WRITE_TOUCH;
          end
        end
        REQ_WIDTH_MAJOR: begin
          // The width is only ever used as the divisor of a report, so it travels with it.
          if (live && pending_q) begin
            push_o    = 1'b1;
            cmd_o.op  = CMD_REPORT;
            pending_d = 1'b0;
          end
        end
        REQ_IGNORED: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_slot_q <= '0;
      open_q     <= '0;
      open_cnt_q <= '0;
      pending_q  <= 1'b0;
    end else begin
      cur_slot_q <= cur_slot_d;
      open_q     <= open_d;
      open_cnt_q <= open_cnt_d;
      pending_q  <= pending_d;
    end
  end

endmodule

FILE: src/mst_back.sv
module mst_back import mst_pkg::*; #(
  parameter int unsigned SLOT_COUNT = DEF_SLOT_COUNT
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cmd_t          head_i,
  input  queue_status_t qstat_i,
  output logic          pop_o,
  output logic          result_valid_o,
  output res_t          result_o
);

  localparam int unsigned SLOT_W = $clog2(SLOT_COUNT);

  typedef enum logic [1:0] {
    B_IDLE,
    B_READ,
    B_DIVIDE
  } back_state_e;

  back_state_e       state_q, state_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [31:0]       div_q, div_d;
  logic [31:0]       quot_q, quot_d;
  logic [31:0]       rem_q, rem_d;
  logic [4:0]        cnt_q, cnt_d;
  res_t              res_q, res_d;
  logic              valid_q, valid_d;

  logic              x_we, y_we, tm_we;
  logic [31:0]       wdata;
  logic [31:0]       x_rd, y_rd, tm_rd;
  logic [32:0]       rem_sh, diff;

  mst_ram #(.WIDTH(32), .DEPTH(SLOT_COUNT)) u_ram_x (
    .clk_i  (clk_i),
    .we_i   (x_we),
    .waddr_i(head_i.slot[SLOT_W-1:0]),
    .wdata_i(wdata),
    .raddr_i(head_i.slot[SLOT_W-1:0]),
    .rdata_o(x_rd)
  );

  mst_ram #(.WIDTH(32), .DEPTH(SLOT_COUNT)) u_ram_y (
    .clk_i  (clk_i),
    .we_i   (y_we),
    .waddr_i(head_i.slot[SLOT_W-1:0]),
    .wdata_i(wdata),
    .raddr_i(head_i.slot[SLOT_W-1:0]),
    .rdata_o(y_rd)
  );

  mst_ram #(.WIDTH(32), .DEPTH(SLOT_COUNT)) u_ram_tm (
    .clk_i  (clk_i),
    .we_i   (tm_we),
    .waddr_i(head_i.slot[SLOT_W-1:0]),
    .wdata_i(wdata),
    .raddr_i(head_i.slot[SLOT_W-1:0]),
    .rdata_o(tm_rd)
  );

  // One restoring step: the next dividend bit enters the remainder from the top of quot_q.
  assign rem_sh = {rem_q, quot_q[31]};
  assign diff   = rem_sh - {1'b0, div_q};

  always_comb begin
    state_d = state_q;
    slot_d  = slot_q;
    div_d   = div_q;
    quot_d  = quot_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    res_d   = res_q;
    valid_d = 1'b0;
    pop_o   = 1'b0;
    x_we    = 1'b0;
    y_we    = 1'b0;
    tm_we   = 1'b0;
    wdata   = (head_i.op == CMD_CLEAR) ? '0 : head_i.value;

    unique case (state_q)
      B_IDLE: begin
        if (!qstat_i.empty) begin
          pop_o = 1'b1;
          case (head_i.op)
            CMD_CLEAR: begin
              x_we  = 1'b1;
              y_we  = 1'b1;
              tm_we = 1'b1;
            end
            CMD_WRITE_X:     x_we = 1'b1;
            CMD_WRITE_Y:     y_we = 1'b1;
            CMD_WRITE_TOUCH: tm_we = 1'b1;
            CMD_REPORT: begin
              slot_d  = head_i.slot[SLOT_W-1:0];
              div_d   = head_i.value;
              state_d = B_READ;
            end
            default: begin
            end
          endcase
        end
      end
      B_READ: begin
        res_d.slot_number = 4'(slot_q);
        res_d.pos_x       = x_rd;
        res_d.pos_y       = y_rd;
        if (div_q == '0) begin
          res_d.size_ratio   = '0;
          res_d.divide_fault = 1'b1;
          valid_d            = 1'b1;
          state_d            = B_IDLE;
        end else begin
          res_d.divide_fault = 1'b0;
          quot_d             = tm_rd;
          rem_d              = '0;
          cnt_d              = '0;
          state_d            = B_DIVIDE;
        end
      end
      B_DIVIDE: begin
        if (!diff[32]) begin
          rem_d  = diff[31:0];
          quot_d = {quot_q[30:0], 1'b1};
        end else begin
          rem_d  = rem_sh[31:0];
          quot_d = {quot_q[30:0], 1'b0};
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 5'd31) begin
          res_d.size_ratio = quot_d;
          valid_d          = 1'b1;
          state_d          = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      slot_q  <= '0;
      div_q   <= '0;
      quot_q  <= '0;
      rem_q   <= '0;
      cnt_q   <= '0;
      res_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      slot_q  <= slot_d;
      div_q   <= div_d;
      quot_q  <= quot_d;
      rem_q   <= rem_d;
      cnt_q   <= cnt_d;
      res_q   <= res_d;
      valid_q <= valid_d;
    end
  end

  assign result_valid_o = valid_q;
  assign result_o       = res_q;

endmodule

FILE: src/mst_checker.sv
module mst_checker import mst_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic result_valid_o,
  input res_t result_o
);

  // Every report passes through a pop and the store read, so a report pulse is never
  // followed directly by another.
  a_report_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !$past(result_valid_o, 1))
    else $error("reports closer than two cycles");

  a_fault_ratio_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.divide_fault |-> result_o.size_ratio == '0)
    else $error("divide fault with a nonzero ratio");

  // No report can leave straight after reset release.
  a_no_early_report: assert property (@(posedge clk_i)
    !rst_ni |=> !result_valid_o ##1 !result_valid_o)
    else $error("report too soon after reset");

  // The queue only fills on an accepted transaction.
  a_busy_from_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("busy rose without an accepted event");

endmodule

bind multitouch_slot_tracker_top mst_checker u_mst_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .result_valid_o(result_valid_o),
  .result_o      (result_o)
);

FILE: dv/multitouch_slot_tracker_top_tb.sv
module multitouch_slot_tracker_top_tb;
  import mst_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SLOT_COUNT   = DEF_SLOT_COUNT;
  localparam logic [2:0]  REQ_RESERVED = 3'd7;
  localparam int          ITEM_TARGET  = 1350;
  localparam int          STALL_LIMIT  = 1000;
  localparam int          REPORT_TAIL  = 40;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start;
  logic busy;
  req_t req_i;
  logic result_valid_o;
  res_t result_o;

  multitouch_slot_tracker_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .req_i         (req_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Tracker state as the block should hold it.
  logic [3:0]  trk_slot;
  logic        trk_open [SLOT_COUNT];
  int          trk_open_cnt;
  logic [31:0] trk_x     [SLOT_COUNT];
  logic [31:0] trk_y     [SLOT_COUNT];
  logic [31:0] trk_touch [SLOT_COUNT];
  logic [31:0] trk_width [SLOT_COUNT];
  logic        trk_pending;

  res_t expected_reports[$];
  int   errors;
  int   events_sent;
  int   burst_left;
  int   stall_cycles;

  function automatic void clear_tracker();
    trk_slot     = '0;
    trk_open_cnt = 0;
    trk_pending  = 1'b0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      trk_open[i]  = 1'b0;
      trk_x[i]     = '0;
      trk_y[i]     = '0;
      trk_touch[i] = '0;
      trk_width[i] = '0;
    end
  endfunction

  // Applies one event to the tracker state; returns 1 when it yields a report.
  function automatic bit track_event(input req_t ev, output res_t rpt);
    logic [3:0] s;
    bit live;
    bit fired;
    s     = trk_slot;
    live  = trk_open[s];
    fired = 1'b0;
    rpt   = '0;
    case (ev.req_type)
      REQ_SLOT: begin
        if (ev.event_value < SLOT_COUNT) trk_slot = ev.event_value[3:0];
      end
      REQ_TRACK_ID: begin
        if (ev.event_value != LIFT_VALUE) begin
          if (!trk_open[s]) begin
            trk_open[s]  = 1'b1;
            trk_open_cnt++;
            trk_x[s]     = '0;
            trk_y[s]     = '0;
            trk_touch[s] = '0;
            trk_width[s] = '0;
          end
        end else begin
          if (trk_open[s]) begin
            trk_open[s] = 1'b0;
            trk_open_cnt--;
          end
          // Even a lift of a closed slot sends the selection back to slot 0 when at most one slot stays open.
          if (trk_open_cnt <= 1) trk_slot = '0;
        end
      end
      REQ_POS_X: begin
        if (live) begin
          trk_x[s]    = ev.event_value;
          trk_pending = 1'b1;
        end
      end
      REQ_POS_Y:       if (live) trk_y[s] = ev.event_value;
      REQ_TOUCH_MAJOR: if (live) trk_touch[s] = ev.event_value;
      REQ_WIDTH_MAJOR: begin
        if (live) begin
          trk_width[s] = ev.event_value;
          if (trk_pending) begin
            fired            = 1'b1;
            rpt.slot_number  = s;
            rpt.pos_x        = trk_x[s];
            rpt.pos_y        = trk_y[s];
            rpt.divide_fault = (ev.event_value == '0);
            rpt.size_ratio   = rpt.divide_fault ? '0 : trk_touch[s] / ev.event_value;
            trk_pending      = 1'b0;
          end
        end
      end
      default: ;
    endcase
    return fired;
  endfunction

  task automatic compare_report(input res_t want, input res_t got);
    if (got.slot_number !== want.slot_number) begin
      $error("slot_number: expected %0d, got %0d", want.slot_number, got.slot_number);
      errors++;
    end
    if (got.pos_x !== want.pos_x) begin
      $error("pos_x: expected %h, got %h", want.pos_x, got.pos_x);
      errors++;
    end
    if (got.pos_y !== want.pos_y) begin
      $error("pos_y: expected %h, got %h", want.pos_y, got.pos_y);
      errors++;
    end
    if (got.size_ratio !== want.size_ratio) begin
      $error("size_ratio: expected %h, got %h", want.size_ratio, got.size_ratio);
      errors++;
    end
    if (got.divide_fault !== want.divide_fault) begin
      $error("divide_fault: expected %b, got %b", want.divide_fault, got.divide_fault);
      errors++;
    end
  endtask

  // Checks reports, predicts each accepted transaction and watches for a hang.
  always @(posedge clk_i) begin
    res_t rpt;
    bit   progress;
    if (rst_ni) begin
      progress = 1'b0;
      if (result_valid_o) begin
        progress = 1'b1;
        if (expected_reports.size() == 0) begin
          $error("report with none expected: slot %0d", result_o.slot_number);
          errors++;
        end else begin
          compare_report(expected_reports.pop_front(), result_o);
        end
      end
      if (start && !busy) begin
        progress = 1'b1;
        if (track_event(req_i, rpt)) expected_reports.push_back(rpt);
      end
      stall_cycles = progress ? 0 : stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("multitouch_slot_tracker_top_tb: done, errors");
        $finish;
      end
    end
  end

  task automatic send_event(input logic [2:0] kind, input logic [31:0] value);
    int gap;
    if (burst_left == 0) begin
      gap   = $urandom_range(1, 8);
      start = 1'b0;
      repeat (gap) @(negedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 12);
    end
    burst_left--;
    start             = 1'b1;
    req_i.req_type    = kind;
    req_i.event_value = value;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
    if (kind <= 3'(REQ_WIDTH_MAJOR)) events_sent++;
  endtask

  task automatic wait_drained();
    start = 1'b0;
    while (expected_reports.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic [31:0] any_value();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return LIFT_VALUE;
      2:       return $urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] width_value();
    case ($urandom_range(0, 15))
      0:       return '0;
      1, 2:    return 32'd1;
      3, 4, 5: return $urandom_range(2, 64);
      default: return any_value();
    endcase
  endfunction

  // Out of reset all slots are closed, so writes do nothing and nothing reports.
  task automatic test_closed_slots();
    send_event(REQ_WIDTH_MAJOR, 32'd5);
    send_event(REQ_POS_X, LIFT_VALUE);
    send_event(REQ_WIDTH_MAJOR, 32'd3);
    send_event(REQ_IGNORED, 32'h1234_5678);
    send_event(REQ_RESERVED, LIFT_VALUE);
    send_event(REQ_TRACK_ID, LIFT_VALUE);
  endtask

  task automatic test_single_contact();
    send_event(REQ_TRACK_ID, 32'd0);
    send_event(REQ_POS_X, LIFT_VALUE);
    send_event(REQ_POS_Y, 32'd0);
    send_event(REQ_TOUCH_MAJOR, LIFT_VALUE);
    send_event(REQ_WIDTH_MAJOR, 32'd1);
    send_event(REQ_POS_X, 32'd0);
    send_event(REQ_WIDTH_MAJOR, 32'd0);
    send_event(REQ_POS_X, 32'd7);
    send_event(REQ_TOUCH_MAJOR, 32'd3);
    send_event(REQ_WIDTH_MAJOR, LIFT_VALUE);
  endtask

  task automatic test_slot_select();
    send_event(REQ_SLOT, 32'd16);
    send_event(REQ_SLOT, LIFT_VALUE);
    send_event(REQ_SLOT, 32'd15);
    send_event(REQ_TRACK_ID, 32'd5);
    send_event(REQ_POS_Y, 32'hA5A5_5A5A);
    // A second open must keep the stored values.
    send_event(REQ_TRACK_ID, 32'd123);
    send_event(REQ_POS_X, 32'd1);
    send_event(REQ_WIDTH_MAJOR, 32'd2);
    send_event(REQ_TRACK_ID, LIFT_VALUE);
    send_event(REQ_TRACK_ID, LIFT_VALUE);
  endtask

  task automatic test_random_frames();
    logic [2:0] kind;
    while (events_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          kind = 3'($urandom_range(0, 7));
          send_event(kind, (kind == 3'(REQ_SLOT) && $urandom_range(0, 3) != 0) ?
                     32'($urandom_range(0, 20)) : any_value());
        end
      end else begin
        if ($urandom_range(0, 11) == 0) send_event(REQ_SLOT, $urandom_range(16, LIFT_VALUE));
        else send_event(REQ_SLOT, $urandom_range(0, SLOT_COUNT - 1));
        if ($urandom_range(0, 4) != 0) send_event(REQ_TRACK_ID, $urandom & 32'h7FFF_FFFF);
        if ($urandom_range(0, 9) != 0) send_event(REQ_POS_X, any_value());
        if ($urandom_range(0, 4) != 0) send_event(REQ_POS_Y, any_value());
        if ($urandom_range(0, 4) != 0) send_event(REQ_TOUCH_MAJOR, any_value());
        if ($urandom_range(0, 9) != 0) send_event(REQ_WIDTH_MAJOR, width_value());
        if ($urandom_range(0, 5) == 0) send_event(REQ_TRACK_ID, LIFT_VALUE);
      end
      if ($urandom_range(0, 99) == 0) wait_drained();
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    start        = 1'b0;
    req_i        = '0;
    errors       = 0;
    events_sent  = 0;
    burst_left   = 0;
    stall_cycles = 0;
    clear_tracker();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_closed_slots();
    test_single_contact();
    test_slot_select();
    wait_drained();
    test_random_frames();

    wait_drained();
    repeat (REPORT_TAIL) @(negedge clk_i);
    if (expected_reports.size() != 0) begin
      $error("%0d reports never arrived", expected_reports.size());
      errors++;
    end
    if (errors == 0) begin
      $display("multitouch_slot_tracker_top_tb: done, clean");
    end else begin
      $display("multitouch_slot_tracker_top_tb: done, errors");
    end
    $finish;
  end

endmodule

FILE: multitouch_slot_tracker_top.f
src/mst_pkg.sv
src/mst_ram.sv
src/mst_cmd_queue.sv
src/mst_front.sv
src/mst_back.sv
src/multitouch_slot_tracker_top.sv
src/mst_checker.sv
dv/multitouch_slot_tracker_top_tb.sv
